>>> hw/rtl/dct_8x8_forward_top_defines.svh
// Assertion macros shared by the checker of the 8x8 forward DCT.
// No dependencies; included by the checker file only.
`ifndef DCT_8X8_FORWARD_TOP_DEFINES_SVH
`define DCT_8X8_FORWARD_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCT_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/dct_pkg.sv
// Shared types, constants and the cosine basis of the 8x8 forward DCT.
// No dependencies; imported by every module of the block.
package dct_pkg;

  localparam int PIXEL_BITS_DEF     = 8;
  localparam int COEF_FRAC_BITS_DEF = 4;
  localparam int COEF_W             = 16;
  localparam int IDX_W              = 6;
  localparam int KW                 = 15;  // signed basis, 14 fractional bits
  localparam int ISS_W              = 9;   // 64 elements times 8 terms

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROW,
    BK_COL
  } back_state_t;

  // Status of the block queue as seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
    logic head_bank;
  } q_stat_t;

  // 8192 * cos(m*pi/16).
  function automatic logic [13:0] dct_cos(input logic [3:0] m);
    logic [13:0] c;
    case (m)
      4'd0:    c = 14'd8192;
      4'd1:    c = 14'd8035;
      4'd2:    c = 14'd7568;
      4'd3:    c = 14'd6811;
      4'd4:    c = 14'd5793;
      4'd5:    c = 14'd4551;
      4'd6:    c = 14'd3135;
      4'd7:    c = 14'd1598;
      default: c = 14'd0;
    endcase
    return c;
  endfunction

  // Basis value a(u)/2 * cos((2x+1)u*pi/16) with 14 fractional bits.
  function automatic logic signed [KW-1:0] dct_basis(input logic [2:0] u,
                                                      input logic [2:0] x);
    logic [6:0] prod;
    logic [4:0] m;
    logic [4:0] mm;
    logic [4:0] idx;
    logic       neg;
    logic [13:0] c;
    prod = {x, 1'b1} * u;
    m    = prod[4:0];
    mm   = (m > 5'd16) ? 5'd0 - m : m;
    neg  = (mm > 5'd8);
    idx  = neg ? 5'd16 - mm : mm;
    c    = dct_cos(idx[3:0]);
    if (u == 3'd0) begin
      return KW'(5793);
    end
    return neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
  endfunction

endpackage

>>> hw/rtl/dct_queue.sv
// Two-entry queue of filled pixel banks between front and back.
// Depends on dct_pkg for the status struct.
module dct_queue
  import dct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  logic    push_bank,
  input  logic    pop,
  output q_stat_t stat
);

  logic [1:0] slot_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bank;
    end
  end

  assign stat.empty     = (count_r == 2'd0);
  assign stat.full      = (count_r == 2'd2);
  assign stat.head_bank = slot_r[rd_ptr_r];

endmodule

>>> hw/rtl/dct_front.sv
// Input side: collects pixels into a two-bank block memory and queues full banks.
// Depends on dct_pkg.
module dct_front
  import dct_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic                  push_bank,
  input  logic                  rd_en,
  input  logic [IDX_W:0]        rd_addr,
  output logic [PIXEL_BITS-1:0] rd_data
);

  logic [PIXEL_BITS-1:0] mem [2*64];
  logic [IDX_W-1:0]      cnt_r;
  logic                  bank_r;
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  take;

  // Both banks busy means the queue is full.
  assign in_ready  = !q_stat.full;
  assign take      = in_valid && in_ready;
  assign push      = take && (&cnt_r);
  assign push_bank = bank_r;
  assign rd_data   = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      if (&cnt_r) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[{bank_r, cnt_r}] <= in_pixel;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/dct_back.sv
// Transform engine: one shared multiply-accumulate for the row and column passes.
// Depends on dct_pkg; reads pixels from dct_front, pops dct_queue.
module dct_back
  import dct_pkg::*;
#(
  parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  q_stat_t                  q_stat,
  output logic                     pop,
  output logic                     rd_en,
  output logic [IDX_W:0]           rd_addr,
  input  logic [PIXEL_BITS-1:0]    rd_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [IDX_W-1:0]         out_coef_index,
  output logic                     out_last
);

  localparam int RW = PIXEL_BITS + 17;  // row-pass value, 14 fractional bits
  localparam int PW = RW + KW;          // product width
  localparam int SW = PIXEL_BITS + 33;  // column sum, 28 fractional bits
  localparam int SH = 28 - COEF_FRAC_BITS;

  back_state_t state_r, state_nxt;
  logic [ISS_W-1:0] iss_r;
  logic             en;
  logic             issue;
  logic             issue_col;
  logic             iss_end;
  logic [IDX_W-1:0] elem;
  logic [2:0]       term;

  logic signed [RW-1:0] rs_mem [64];
  logic signed [RW-1:0] rs_rd_r;

  logic                  s1_vld_r, s1_col_r, s1_first_r, s1_lastt_r;
  logic [IDX_W-1:0]      s1_elem_r;
  logic signed [KW-1:0]  s1_k_r;
  logic                  s2_vld_r, s2_col_r, s2_first_r, s2_lastt_r;
  logic [IDX_W-1:0]      s2_elem_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [SW-1:0]  acc_r;
  logic signed [SW-1:0]  acc_sum;
  logic signed [RW-1:0]  opnd;

  logic                  neg;
  logic [SW-1:0]         mag;
  logic [SW-1:0]         q;
  logic [SW-1:0]         neg_q;
  logic signed [COEF_W-1:0] coef;

  logic                     out_valid_r;
  logic signed [COEF_W-1:0] out_coef_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic                     out_last_r;

  // The whole pipeline holds while a finished coefficient waits.
  assign en      = !out_valid_r || out_ready;
  assign elem    = iss_r[ISS_W-1:3];
  assign term    = iss_r[2:0];
  assign iss_end = &iss_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_ROW;
      BK_ROW:  if (en && iss_end) state_nxt = BK_COL;
      BK_COL:  if (en && iss_end) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    issue     = 1'b0;
    issue_col = 1'b0;
    unique case (state_r)
      BK_IDLE: ;
      BK_ROW:  issue = 1'b1;
      BK_COL: begin
        issue     = 1'b1;
        issue_col = 1'b1;
      end
      default: ;
    endcase
  end

  // The bank is released once its last pixel has been read.
  assign pop     = en && (state_r == BK_ROW) && iss_end;
  assign rd_en   = en && issue && !issue_col;
  assign rd_addr = {q_stat.head_bank, elem[5:3], term};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      iss_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (en) begin
        if (issue) begin
          iss_r <= iss_r + 1'b1;
        end
        s1_vld_r    <= issue;
        s2_vld_r    <= s1_vld_r;
        out_valid_r <= s2_vld_r && s2_col_r && s2_lastt_r;
      end
    end
  end

  // Stage 1: basis lookup and operand reads.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_col_r   <= issue_col;
      s1_first_r <= (term == 3'd0);
      s1_lastt_r <= (term == 3'd7);
      s1_elem_r  <= elem;
      s1_k_r     <= issue_col ? dct_basis(elem[5:3], term) : dct_basis(elem[2:0], term);
      rs_rd_r    <= rs_mem[{term, elem[2:0]}];
    end
  end

  assign opnd = s1_col_r ? rs_rd_r : $signed(RW'(rd_data));

  // Stage 2: product.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_col_r   <= s1_col_r;
      s2_first_r <= s1_first_r;
      s2_lastt_r <= s1_lastt_r;
      s2_elem_r  <= s1_elem_r;
      prod_r     <= PW'(opnd * s1_k_r);
    end
  end

  // Stage 3: accumulate, store row results, finish column results.
  assign acc_sum = (s2_first_r ? SW'(0) : acc_r) + SW'(prod_r);

  always_comb begin
    neg   = acc_sum[SW-1];
    mag   = neg ? SW'(-acc_sum) : SW'(acc_sum);
    q     = (mag + (SW'(1) << (SH - 1))) >> SH;
    neg_q = SW'(0) - q;
    if (!neg) begin
      coef = (q > SW'(32767)) ? COEF_W'(32767) : $signed(q[COEF_W-1:0]);
    end else begin
      coef = (q > SW'(32768)) ? $signed({1'b1, {(COEF_W-1){1'b0}}})
                              : $signed(neg_q[COEF_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_vld_r) begin
      acc_r <= acc_sum;
      if (s2_lastt_r && !s2_col_r) begin
        rs_mem[s2_elem_r] <= acc_sum[RW-1:0];
      end
    end
    if (en) begin
      out_coef_r <= coef;
      out_idx_r  <= s2_elem_r;
      out_last_r <= &s2_elem_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_coef_index  = out_idx_r;
  assign out_last        = out_last_r;

endmodule

>>> hw/rtl/dct_8x8_forward_top.sv
// Top level of the 8x8 forward DCT-II: front, block queue and transform engine.
// Depends on dct_pkg, dct_front, dct_queue and dct_back.
//
// Pixels of one 8x8 block enter in raster order, one per transaction, and are
// written into one of two pixel banks; after the 64th pixel the bank is queued
// and the next block fills the other bank at one pixel per cycle while a bank is
// free. The engine computes each block with a single multiply-accumulate unit:
// a row pass over all 64 elements, then a column pass over the stored row
// results; each coefficient is registered at the output once the product and
// accumulate stages have taken its last
// column term. Coefficients come out in order index = u + 8*v, with 16-bit
// signed values carrying COEF_FRAC_BITS fractional bits, rounded to nearest
// (ties away from zero) and saturated; last marks index 63. A stalled output
// freezes the engine, while the input keeps taking pixels as long as a bank
// is free.
module dct_8x8_forward_top
  import dct_pkg::*;
#(
  parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIXEL_BITS-1:0]    in_pixel,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [IDX_W-1:0]         out_coef_index,
  output logic                     out_last
);

  q_stat_t               q_stat;
  logic                  push;
  logic                  push_bank;
  logic                  pop;
  logic                  rd_en;
  logic [IDX_W:0]        rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;

  // Front: pixel collection into the two banks.
  dct_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .q_stat    (q_stat),
    .push      (push),
    .push_bank (push_bank),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Queue of filled banks waiting for the engine.
  dct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_bank (push_bank),
    .pop       (pop),
    .stat      (q_stat)
  );

  // Back: row and column passes and output register.
  dct_back #(
    .PIXEL_BITS     (PIXEL_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop             (pop),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_coefficient (out_coefficient),
    .out_coef_index  (out_coef_index),
    .out_last        (out_last)
  );

endmodule

>>> hw/rtl/dct_chk.sv
// Port-level checker for the 8x8 forward DCT, bound to the top level.
// Depends on dct_pkg and dct_8x8_forward_top_defines.svh.
`include "dct_8x8_forward_top_defines.svh"

module dct_chk
  import dct_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COEF_W-1:0] out_coefficient,
  input logic [IDX_W-1:0]         out_coef_index,
  input logic                     out_last
);

  logic [IDX_W-1:0] pix_cnt_r;
  logic [IDX_W-1:0] exp_idx_r;
  logic [2:0]       blk_pend_r;
  logic             blk_in;
  logic             blk_out;

  assign blk_in  = in_valid && in_ready && (&pix_cnt_r);
  assign blk_out = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= '0;
      exp_idx_r  <= '0;
      blk_pend_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pix_cnt_r <= pix_cnt_r + 1'b1;
      end
      if (out_valid && out_ready) begin
        exp_idx_r <= exp_idx_r + 1'b1;
      end
      blk_pend_r <= blk_pend_r + {2'b00, blk_in} - {2'b00, blk_out};
    end
  end

  // Coefficients leave in index order.
  `DCT_ASSERT_NOW(a_idx_order, clk, rst_n, out_valid, out_coef_index == exp_idx_r, "coefficient index out of order")
  // Last marks exactly index 63.
  `DCT_ASSERT_NOW(a_last_idx, clk, rst_n, out_valid, out_last == (&out_coef_index), "last flag does not match index")
  // No coefficient before its block has fully arrived.
  `DCT_ASSERT_NOW(a_no_early, clk, rst_n, out_valid, blk_pend_r != 3'd0, "coefficient without a complete block")
  // A stalled coefficient holds.
  `DCT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_coefficient) && $stable(out_coef_index), "stalled output changed")

endmodule

bind dct_8x8_forward_top dct_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_coefficient (out_coefficient),
  .out_coef_index  (out_coef_index),
  .out_last        (out_last)
);
